@@ src/mi3_pkg.sv @@
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 adjugate matrix inverse pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mi3_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // matrix geometry
   localparam int MAT_DIM  = 3;
   localparam int NUM_ELEM = MAT_DIM * MAT_DIM;

endpackage

@@ src/matrix_inverse_3x3.sv @@
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 matrix inverse by the adjugate in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Channel    Ports                          Direction  Handshake
// request    req_a00 .. req_a22             in         start high, busy low
// response   rsp_b00 .. rsp_b22, rsp_determinant,
//            rsp_singular, rsp_saturated    out        rsp_strobe, 1 cycle
//
// One matrix is accepted every cycle; busy never rises. The strobe rises
// after the input register, the cofactor and determinant stages, the
// divider pipeline (one quotient bit per stage) and the response
// registers. Reset clears only the valid bits; transactions in flight
// are dropped. The receiver cannot stall, so nothing holds the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_inverse_3x3 import mi3_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_a00,
   input  logic signed [DATA_WIDTH-1:0] req_a01,
   input  logic signed [DATA_WIDTH-1:0] req_a02,
   input  logic signed [DATA_WIDTH-1:0] req_a10,
   input  logic signed [DATA_WIDTH-1:0] req_a11,
   input  logic signed [DATA_WIDTH-1:0] req_a12,
   input  logic signed [DATA_WIDTH-1:0] req_a20,
   input  logic signed [DATA_WIDTH-1:0] req_a21,
   input  logic signed [DATA_WIDTH-1:0] req_a22,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_b00,
   output logic signed [DATA_WIDTH-1:0] rsp_b01,
   output logic signed [DATA_WIDTH-1:0] rsp_b02,
   output logic signed [DATA_WIDTH-1:0] rsp_b10,
   output logic signed [DATA_WIDTH-1:0] rsp_b11,
   output logic signed [DATA_WIDTH-1:0] rsp_b12,
   output logic signed [DATA_WIDTH-1:0] rsp_b20,
   output logic signed [DATA_WIDTH-1:0] rsp_b21,
   output logic signed [DATA_WIDTH-1:0] rsp_b22,
   output logic signed [DATA_WIDTH-1:0] rsp_determinant,
   output logic                         rsp_singular,
   output logic                         rsp_saturated
);

   localparam int DW    = DATA_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int MW    = 2 * DW + 1;
   localparam int DTW   = 3 * DW + 3;
   localparam int DLAT  = DW + 2;          // divider latency
   localparam int HSH   = (FB == 0) ? 0 : 2 * FB - 1;
   localparam logic [DTW:0] HALF = (FB == 0) ? '0 : ((DTW+1)'(1) << HSH);

   // input register
   logic signed [DW-1:0] a_ff [NUM_ELEM];
   logic signed [DW-1:0] a_in [NUM_ELEM];
   logic                 v0_ff;

   // cofactor and determinant stages
   logic                 cof_valid;
   logic signed [MW-1:0] cof [NUM_ELEM];
   logic signed [DW-1:0] row0 [MAT_DIM];
   logic                 det_valid;
   logic signed [DTW-1:0] det;

   // cofactors delayed through the cofd_ff registers to meet the determinant
   logic signed [MW-1:0] cofd_ff [3][NUM_ELEM];

   // divider outputs
   logic signed [DW-1:0] quo [NUM_ELEM];
   logic [NUM_ELEM-1:0]  qsat;

   // determinant rounding, then a delay line matching the dividers
   logic [DTW-1:0]       dmag;
   logic [DTW:0]         dsum;
   logic [DTW:0]         dq;
   logic [DTW:0]         dlim;
   logic [DTW:0]         dclip;
   logic                 dsat_in;
   logic [DW-1:0]        dval_in;
   logic                 dsing_in;
   logic [DW-1:0]        dval_ff  [DLAT];
   logic                 dsat_ff  [DLAT];
   logic                 dsing_ff [DLAT];
   logic [DLAT-1:0]      dvalid_ff;

   // response registers
   logic signed [DW-1:0] b_in [NUM_ELEM];
   logic signed [DW-1:0] b_ff [NUM_ELEM];
   logic [DW-1:0]        det_out_in;
   logic [DW-1:0]        det_out_ff;
   logic                 sing_ff;
   logic                 sat_out_in;
   logic                 sat_out_ff;
   logic                 strobe_ff;

   // no backpressure anywhere downstream
   assign busy = 1'b0;

   assign a_in[0] = req_a00;
   assign a_in[1] = req_a01;
   assign a_in[2] = req_a02;
   assign a_in[3] = req_a10;
   assign a_in[4] = req_a11;
   assign a_in[5] = req_a12;
   assign a_in[6] = req_a20;
   assign a_in[7] = req_a21;
   assign a_in[8] = req_a22;

   always_ff @(posedge clock) begin
      a_ff <= a_in;
   end

   mi3_cofactor #(
      .DW (DW)
   ) u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .a         (a_ff),
      .out_valid (cof_valid),
      .cof       (cof),
      .row0      (row0)
   );

   mi3_det #(
      .DW (DW)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .row0      (row0),
      .cof       (cof),
      .out_valid (det_valid),
      .det       (det)
   );

   always_ff @(posedge clock) begin
      cofd_ff[0] <= cof;
      cofd_ff[1] <= cofd_ff[0];
      cofd_ff[2] <= cofd_ff[1];
   end

   genvar gi;
   for (gi = 0; gi < NUM_ELEM; gi++) begin : g_div
      // b[r][c] = cof[c][r] / det
      localparam int SRC = (gi % MAT_DIM) * MAT_DIM + (gi / MAT_DIM);

      mi3_divider #(
         .DW (DW),
         .FB (FB)
      ) u_divider (
         .clock (clock),
         .cof   (cofd_ff[2][SRC]),
         .det   (det),
         .quo   (quo[gi]),
         .sat   (qsat[gi])
      );
   end

   // determinant / 2^(2*FB), round half away from zero, clip
   assign dmag     = det[DTW-1] ? DTW'(-det) : DTW'(det);
   assign dsum     = (DTW+1)'(dmag) + HALF;
   assign dq       = dsum >> (2 * FB);
   assign dlim     = det[DTW-1] ? ((DTW+1)'(1) << (DW-1))
                                : ((DTW+1)'(1) << (DW-1)) - (DTW+1)'(1);
   assign dsat_in  = dq > dlim;
   assign dclip    = dsat_in ? dlim : dq;
   assign dval_in  = det[DTW-1] ? -dclip[DW-1:0] : dclip[DW-1:0];
   assign dsing_in = (det == '0);

   always_ff @(posedge clock) begin
      dval_ff[0]  <= dval_in;
      dsat_ff[0]  <= dsat_in;
      dsing_ff[0] <= dsing_in;
      for (int i = 1; i < DLAT; i++) begin
         dval_ff[i]  <= dval_ff[i-1];
         dsat_ff[i]  <= dsat_ff[i-1];
         dsing_ff[i] <= dsing_ff[i-1];
      end
   end

   // singular: all values forced to zero, no saturation reported
   always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         b_in[i] = dsing_ff[DLAT-1] ? '0 : quo[i];
      end
   end

   assign det_out_in = dsing_ff[DLAT-1] ? '0 : dval_ff[DLAT-1];
   assign sat_out_in = !dsing_ff[DLAT-1] && ((|qsat) || dsat_ff[DLAT-1]);

   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      det_out_ff <= det_out_in;
      sing_ff    <= dsing_ff[DLAT-1];
      sat_out_ff <= sat_out_in;
   end

   // valid bits for each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         dvalid_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         v0_ff     <= start && !busy;
         dvalid_ff <= {dvalid_ff[DLAT-2:0], det_valid};
         strobe_ff <= dvalid_ff[DLAT-1];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_b00         = b_ff[0];
   assign rsp_b01         = b_ff[1];
   assign rsp_b02         = b_ff[2];
   assign rsp_b10         = b_ff[3];
   assign rsp_b11         = b_ff[4];
   assign rsp_b12         = b_ff[5];
   assign rsp_b20         = b_ff[6];
   assign rsp_b21         = b_ff[7];
   assign rsp_b22         = b_ff[8];
   assign rsp_determinant = det_out_ff;
   assign rsp_singular    = sing_ff;
   assign rsp_saturated   = sat_out_ff;

endmodule

@@ src/mi3_cofactor.sv @@
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen element products, then the nine signed cofactors.
// Row 0 of the matrix travels alongside for the determinant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_cofactor import mi3_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] a [NUM_ELEM],
   output logic                 out_valid,
   output logic signed [2*DW:0] cof [NUM_ELEM],
   output logic signed [DW-1:0] row0 [MAT_DIM]
);

   localparam int PW = 2 * DW;
   localparam int MW = 2 * DW + 1;

   logic signed [PW-1:0] p0_in [NUM_ELEM];
   logic signed [PW-1:0] p1_in [NUM_ELEM];
   logic signed [PW-1:0] p0_ff [NUM_ELEM];
   logic signed [PW-1:0] p1_ff [NUM_ELEM];
   logic signed [MW-1:0] cof_in [NUM_ELEM];
   logic signed [MW-1:0] cof_ff [NUM_ELEM];
   logic signed [DW-1:0] row_a_ff [MAT_DIM];
   logic signed [DW-1:0] row_b_ff [MAT_DIM];
   logic [1:0]           valid_ff;
   logic [1:0]           valid_in;

   genvar gr, gc;
   for (gr = 0; gr < MAT_DIM; gr++) begin : g_row
      for (gc = 0; gc < MAT_DIM; gc++) begin : g_col
         localparam int R0  = (gr == 0) ? 1 : 0;
         localparam int R1  = (gr == 2) ? 1 : 2;
         localparam int C0  = (gc == 0) ? 1 : 0;
         localparam int C1  = (gc == 2) ? 1 : 2;
         localparam int IDX = gr * MAT_DIM + gc;
         localparam bit ODD = ((gr + gc) % 2) == 1;

         logic signed [MW-1:0] minor;

         assign p0_in[IDX] = PW'(a[R0*MAT_DIM+C0]) * PW'(a[R1*MAT_DIM+C1]);
         assign p1_in[IDX] = PW'(a[R0*MAT_DIM+C1]) * PW'(a[R1*MAT_DIM+C0]);
         assign minor      = MW'(p0_ff[IDX]) - MW'(p1_ff[IDX]);
         assign cof_in[IDX] = ODD ? -minor : minor;
      end
   end

   assign valid_in = {valid_ff[0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         p0_ff[i]  <= p0_in[i];
         p1_ff[i]  <= p1_in[i];
         cof_ff[i] <= cof_in[i];
      end
      for (int i = 0; i < MAT_DIM; i++) begin
         row_a_ff[i] <= a[i];
         row_b_ff[i] <= row_a_ff[i];
      end
   end

   assign out_valid = valid_ff[1];
   assign cof       = cof_ff;
   assign row0      = row_b_ff;

endmodule

@@ src/mi3_det.sv @@
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by first-row expansion: partial products, products, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_det import mi3_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [DW-1:0]   row0 [MAT_DIM],
   input  logic signed [2*DW:0]   cof [NUM_ELEM],
   output logic                   out_valid,
   output logic signed [3*DW+2:0] det
);

   localparam int HW  = 2 * DW + 1;   // partial product width
   localparam int DTW = 3 * DW + 3;

   logic signed [HW-1:0]  lo_in [MAT_DIM];
   logic signed [HW-1:0]  hi_in [MAT_DIM];
   logic signed [HW-1:0]  lo_ff [MAT_DIM];
   logic signed [HW-1:0]  hi_ff [MAT_DIM];
   logic signed [DTW-1:0] prod_in [MAT_DIM];
   logic signed [DTW-1:0] prod_ff [MAT_DIM];
   logic signed [DTW-1:0] det_in;
   logic signed [DTW-1:0] det_ff;
   logic [2:0]            valid_ff;
   logic [2:0]            valid_in;

   // cofactor split into an unsigned low half and a signed high half
   always_comb begin
      for (int i = 0; i < MAT_DIM; i++) begin
         lo_in[i]   = HW'(row0[i]) * HW'($signed({1'b0, cof[i][DW-1:0]}));
         hi_in[i]   = HW'(row0[i]) * HW'($signed(cof[i][2*DW:DW]));
         prod_in[i] = (DTW'(hi_ff[i]) <<< DW) + DTW'(lo_ff[i]);
      end
   end

   assign det_in   = prod_ff[0] + prod_ff[1] + prod_ff[2];
   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAT_DIM; i++) begin
         lo_ff[i]   <= lo_in[i];
         hi_ff[i]   <= hi_in[i];
         prod_ff[i] <= prod_in[i];
      end
      det_ff <= det_in;
   end

   assign out_valid = valid_ff[2];
   assign det       = det_ff;

endmodule

@@ src/mi3_divider.sv @@
// ----------------------------------------------------------------------------
// mi3_divider
// Pipelined restoring divider: (cofactor << 2*FB) / det, one quotient bit
// per stage, rounded half away from zero and saturated.
// Registered at the entry, after every quotient bit and at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_divider import mi3_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic signed [2*DW:0]   cof,
   input  logic signed [3*DW+2:0] det,
   output logic signed [DW-1:0]   quo,
   output logic                   sat
);

   localparam int MW  = 2 * DW + 1;
   localparam int DTW = 3 * DW + 3;
   localparam int RW  = DTW + DW;

   logic [MW-1:0]  cof_mag;
   logic [DTW-1:0] den_mag;
   logic [RW-1:0]  num;

   logic [RW-1:0]  rem_in [DW+1];
   logic [DTW-1:0] den_in [DW+1];
   logic [DW-1:0]  q_in   [DW+1];
   logic           neg_in [DW+1];
   logic           ovf_in [DW+1];
   logic [RW-1:0]  rem_ff [DW+1];
   logic [DTW-1:0] den_ff [DW+1];
   logic [DW-1:0]  q_ff   [DW+1];
   logic           neg_ff [DW+1];
   logic           ovf_ff [DW+1];

   logic [DW:0]    qr;
   logic [DW:0]    lim;
   logic [DW:0]    mag;
   logic           rnd_up;
   logic           sat_in;
   logic [DW-1:0]  quo_in;
   logic [DW-1:0]  quo_ff;
   logic           sat_ff;

   // entry: magnitudes and early overflow (quotient would need > DW bits)
   assign cof_mag   = cof[MW-1] ? MW'(-cof) : MW'(cof);
   assign den_mag   = det[DTW-1] ? DTW'(-det) : DTW'(det);
   assign num       = RW'(cof_mag) << (2 * FB);
   assign rem_in[0] = num;
   assign den_in[0] = den_mag;
   assign q_in[0]   = '0;
   assign neg_in[0] = cof[MW-1] ^ det[DTW-1];
   assign ovf_in[0] = num >= (RW'(den_mag) << DW);

   genvar gk;
   for (gk = 1; gk <= DW; gk++) begin : g_step
      localparam int BIT = DW - gk;
      logic [RW-1:0] trial;
      logic          ge;

      assign trial      = RW'(den_ff[gk-1]) << BIT;
      assign ge         = rem_ff[gk-1] >= trial;
      assign rem_in[gk] = ge ? rem_ff[gk-1] - trial : rem_ff[gk-1];
      assign den_in[gk] = den_ff[gk-1];
      assign q_in[gk]   = {q_ff[gk-1][DW-2:0], ge};
      assign neg_in[gk] = neg_ff[gk-1];
      assign ovf_in[gk] = ovf_ff[gk-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DW; i++) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_in[i];
         q_ff[i]   <= q_in[i];
         neg_ff[i] <= neg_in[i];
         ovf_ff[i] <= ovf_in[i];
      end
   end

   // remainder is below the divisor here, so it fits DTW bits
   assign rnd_up = {rem_ff[DW][DTW-1:0], 1'b0} >= {1'b0, den_ff[DW]};
   assign qr     = (DW+1)'(q_ff[DW]) + (DW+1)'(rnd_up);
   assign lim    = neg_ff[DW] ? ((DW+1)'(1) << (DW-1))
                              : ((DW+1)'(1) << (DW-1)) - (DW+1)'(1);
   assign sat_in = ovf_ff[DW] | (qr > lim);
   assign mag    = sat_in ? lim : qr;
   assign quo_in = neg_ff[DW] ? -mag[DW-1:0] : mag[DW-1:0];

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule
